// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the line parser.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define LRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LRP_ASSERT_NEXT(lbl, pre, post, msg) \
	`LRP_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== sv/lrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and keyword tables for the tag reader line parser.
// Used by lrp_ctrl and the top level; depends on nothing else.
package lrp_pkg;

	localparam int LineBytes = 64;
	localparam int Cap = LineBytes - 1;
	localparam int AddrW = $clog2(LineBytes);
	localparam int TagOffset = 6;

	localparam logic [7:0] ChNul = 8'd0;
	localparam logic [7:0] ChLf = 8'd10;
	localparam logic [7:0] ChCr = 8'd13;
	localparam logic [7:0] ChDel = 8'd127;

	localparam logic [AddrW-1:0] LenNone = AddrW'(4);
	localparam logic [AddrW-1:0] LenInvalid = AddrW'(7);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_PUT,
		ST_EMPTY
	} st_t;

	typedef struct packed {
		logic load;
		logic [6:0] ch;
		logic empty;
		logic last;
	} out_load_t;

	function automatic logic [6:0] kw_none(input logic [AddrW-1:0] p);
		logic [6:0] c;
		c = 7'h00;
		case (p)
			AddrW'(0): c = 7'h4E;
			AddrW'(1): c = 7'h4F;
			AddrW'(2): c = 7'h4E;
			AddrW'(3): c = 7'h45;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] kw_invalid(input logic [AddrW-1:0] p);
		logic [6:0] c;
		c = 7'h00;
		case (p)
			AddrW'(0): c = 7'h49;
			AddrW'(1): c = 7'h4E;
			AddrW'(2): c = 7'h56;
			AddrW'(3): c = 7'h41;
			AddrW'(4): c = 7'h4C;
			AddrW'(5): c = 7'h49;
			AddrW'(6): c = 7'h44;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/lrp_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Generic; no package dependencies.
module lrp_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/lrp_ctrl.sv =====
`timescale 1ns / 1ps
// Line assembly and readout sequencer of the tag reader line parser.
// Depends on lrp_pkg and drives one lrp_ram holding the current line.
module lrp_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,
	input  logic                      slot_free,
	output lrp_pkg::out_load_t        ld
);

	lrp_pkg::st_t state_q, state_n;

	logic [lrp_pkg::AddrW-1:0] len_q;
	logic [lrp_pkg::AddrW-1:0] end_q;
	logic [lrp_pkg::AddrW-1:0] rd_ptr_q;
	logic tag_q;
	logic none_q;
	logic inv_q;

	logic acc;
	logic is_nul;
	logic is_end;
	logic line_tag;
	logic none_hit;
	logic inv_hit;
	logic last_ch;
	logic we;
	logic re;
	logic [6:0] rdata;

	assign acc = s_tvalid && s_tready;
	assign is_nul = (s_tdata == lrp_pkg::ChNul);
	assign is_end = (s_tdata == lrp_pkg::ChLf) || (s_tdata == lrp_pkg::ChCr) ||
		(s_tdata >= lrp_pkg::ChDel) || (len_q == lrp_pkg::AddrW'(lrp_pkg::Cap));
	assign line_tag = !((none_q && (len_q == lrp_pkg::LenNone)) ||
		(inv_q && (len_q == lrp_pkg::LenInvalid)));
	assign none_hit = (len_q < lrp_pkg::LenNone) &&
		(s_tdata[6:0] == lrp_pkg::kw_none(len_q)) && ((len_q == '0) || none_q);
	assign inv_hit = (len_q < lrp_pkg::LenInvalid) &&
		(s_tdata[6:0] == lrp_pkg::kw_invalid(len_q)) && ((len_q == '0) || inv_q);
	assign last_ch = ((rd_ptr_q + lrp_pkg::AddrW'(1)) == end_q);
	assign we = acc && !is_nul && !is_end;

	lrp_ram #(
		.DEPTH(lrp_pkg::LineBytes),
		.WIDTH(7)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(len_q),
		.wdata(s_tdata[6:0]),
		.re   (re),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			lrp_pkg::ST_IDLE: begin
				if (acc && !is_nul && is_end && (len_q != '0)) begin
					if (line_tag && !tag_q) begin
						if (len_q <= lrp_pkg::AddrW'(lrp_pkg::TagOffset)) begin
							state_n = lrp_pkg::ST_EMPTY;
						end else begin
							state_n = lrp_pkg::ST_RD;
						end
					end else if (!line_tag && tag_q) begin
						state_n = lrp_pkg::ST_EMPTY;
					end
				end
			end
			lrp_pkg::ST_RD: begin
				state_n = lrp_pkg::ST_PUT;
			end
			lrp_pkg::ST_PUT: begin
				if (slot_free) begin
					state_n = last_ch ? lrp_pkg::ST_IDLE : lrp_pkg::ST_RD;
				end
			end
			lrp_pkg::ST_EMPTY: begin
				if (slot_free) begin
					state_n = lrp_pkg::ST_IDLE;
				end
			end
			default: state_n = lrp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		re = 1'b0;
		ld = '0;
		unique case (state_q)
			lrp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			lrp_pkg::ST_RD: begin
				re = 1'b1;
			end
			lrp_pkg::ST_PUT: begin
				ld.load = slot_free;
				ld.ch = rdata;
				ld.last = last_ch;
			end
			lrp_pkg::ST_EMPTY: begin
				ld.load = slot_free;
				ld.empty = 1'b1;
				ld.last = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrp_pkg::ST_IDLE;
			len_q <= '0;
			tag_q <= 1'b0;
			none_q <= 1'b0;
			inv_q <= 1'b0;
			end_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			state_q <= state_n;
			if (acc && !is_nul) begin
				if (is_end) begin
					if (len_q != '0) begin
						tag_q <= line_tag;
						end_q <= len_q;
						rd_ptr_q <= lrp_pkg::AddrW'(lrp_pkg::TagOffset);
					end
					len_q <= '0;
				end else begin
					len_q <= len_q + lrp_pkg::AddrW'(1);
					none_q <= none_hit;
					inv_q <= inv_hit;
				end
			end
			if ((state_q == lrp_pkg::ST_PUT) && slot_free) begin
				rd_ptr_q <= rd_ptr_q + lrp_pkg::AddrW'(1);
			end
		end
	end

endmodule

// ===== sv/tag_reader_line_parser.sv =====
`timescale 1ns / 1ps
// Tag reader line parser: collects serial bytes into lines and publishes tag text.
// Top level; depends on lrp_pkg, lrp_ctrl and lrp_ram.
//
// Bytes arrive on the slave stream, one byte per word in s_tdata. A zero byte is
// ignored; CR, LF, any byte of 127 or more, or any byte arriving on a full line of
// 63 characters ends the line. Other bytes are stored in an on-chip line RAM, one
// word per cycle while s_tready is high. A line end that changes the tag state from
// absent to present starts a readout of the characters from offset 6 onward; each
// character is read from the RAM and then loaded into the output register. A change
// from present to absent, or a tag line too short to hold text, yields one empty
// word, loaded into the output register from the sequencer's empty state. The
// master stream carries the character and empty flag in m_tdata and marks the end
// of a run with m_tlast. While a run is being read out s_tready is low. When the
// receiver stalls, the word waits in the output register and the readout pauses;
// the block accepts new bytes as soon as the last word of a run sits in that
// register. Reset clears the line length, the tag state and the output valid flag.
module tag_reader_line_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [6:0] tag_char, [7] empty_res
	output logic       m_tlast
);

	lrp_pkg::out_load_t ld;
	logic vld_q;
	logic [6:0] ch_q;
	logic empty_q;
	logic last_q;
	logic slot_free;

	assign slot_free = !vld_q || m_tready;

	lrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.slot_free(slot_free),
		.ld       (ld)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ld.load) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			ch_q <= ld.ch;
			empty_q <= ld.empty;
			last_q <= ld.last;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata = {empty_q, ch_q};
	assign m_tlast = last_q;

endmodule

// ===== sv/lrp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the tag reader line parser, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lrp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	`LRP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped or changed while stalled")
	`LRP_ASSERT(a_empty_last, (m_tvalid && m_tdata[7]) |-> m_tlast, "empty word without last mark")
	`LRP_ASSERT(a_empty_zero, (m_tvalid && m_tdata[7]) |-> (m_tdata[6:0] == 7'd0), "empty word carries a character")
	`LRP_ASSERT(a_char_nonzero, (m_tvalid && !m_tdata[7]) |-> (m_tdata[6:0] != 7'd0), "published character is zero")
	`LRP_ASSERT(a_busy_stall, (m_tvalid && !m_tlast) |-> !s_tready, "input accepted in the middle of a run")

endmodule

bind tag_reader_line_parser lrp_checker u_lrp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
